>>> rtl/cam_chk_pkg.sv
package cam_chk_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] command_code;
        logic [9:0] expected_length;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  payload_byte;
        logic        reply_ok;
        logic [15:0] frame_length;
    } t_out_beat;

    localparam logic       ACT_START   = 1'b0;
    localparam logic       ACT_BYTE    = 1'b1;

    localparam logic [7:0] SYNC_BYTE   = 8'h76;
    localparam logic [7:0] CMD_CAPTURE = 8'h36;
    localparam logic [7:0] CMD_SETUP   = 8'h31;
    localparam logic [7:0] CMD_LENGTH  = 8'h34;
    localparam logic [7:0] CMD_READ    = 8'h32;
    localparam logic [7:0] LEN_HDR     = 8'h04;

endpackage

>>> rtl/camera_reply_checker.sv
// a beat is registered in the input register when accepted; its result, if any, is loaded into
// the output register once that register is empty or not stalled, and offered from then on
// throughput: one beat per cycle while the output is not stalled, set by the reply state update
// the input register holds its beat while a result waits at a stalled output
// reset (i_rst_n low, synchronous): checker idle, both beat registers empty, match flag set
module camera_reply_checker #(
    parameter int MAX_REPLY = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  cam_chk_pkg::t_in_beat  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output cam_chk_pkg::t_out_beat o_out_data
);
    import cam_chk_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEEK = 2'd1;
    localparam logic [1:0] PH_SYNC = 2'd2;

    localparam logic [9:0] LEN_CAP = (MAX_REPLY > 1023) ? 10'd1023 : 10'(MAX_REPLY);

    logic        r_in_valid;
    t_in_beat    r_in;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic [1:0]  r_phase,  n_phase;
    logic [9:0]  r_count,  n_count;
    logic [9:0]  r_sync,   n_sync;
    logic [7:0]  r_cmd,    n_cmd;
    logic [9:0]  r_len,    n_len;
    logic        r_match,  n_match;
    logic [15:0] r_lenval, n_lenval;

    logic        go;
    logic        res_load;
    t_out_beat   n_res;

    logic [9:0]         len_sat;
    logic [7:0]         rx;
    logic               seek_hit;
    logic [1:0]         ph_b;
    logic [9:0]         sync_b;
    logic signed [10:0] roff;
    logic signed [11:0] pay_lim;
    logic               pay_b;
    logic               fits_b;
    logic               match_b;
    logic [15:0]        lenval_b;
    logic [9:0]         count_b;
    logic signed [10:0] lo;
    logic               vok;
    logic               vd_b;

    function automatic logic byte_fits(logic signed [10:0] r, logic [7:0] v,
                                       logic [7:0] c, logic [9:0] len);
        logic signed [11:0] d;
        logic [7:0]         tail_exp;
        logic               ok;
        d        = $signed({r[10], r}) - $signed({2'b00, len}) + 12'sd5;
        tail_exp = (d == 12'sd0) ? SYNC_BYTE : ((d == 12'sd2) ? CMD_READ : 8'h00);
        ok       = 1'b1;
        if (r == 11'sd0 && v != SYNC_BYTE) ok = 1'b0;
        if ((r == 11'sd1 || r == 11'sd3) && v != 8'h00) ok = 1'b0;
        if (r == 11'sd2 && v != c) ok = 1'b0;
        if ((c == CMD_CAPTURE || c == CMD_SETUP) && r == 11'sd4 && v != 8'h00) ok = 1'b0;
        if (c == CMD_LENGTH) begin
            if (r == 11'sd4 && v != LEN_HDR) ok = 1'b0;
            if ((r == 11'sd5 || r == 11'sd6) && v != 8'h00) ok = 1'b0;
        end
        if (c == CMD_READ) begin
            if (r == 11'sd4 && v != 8'h00) ok = 1'b0;
            if (d >= 12'sd0 && d <= 12'sd4 && v != tail_exp) ok = 1'b0;
        end
        return ok;
    endfunction

    assign go          = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // byte step, evaluated against the current reply state
    assign rx       = r_in.rx_byte;
    assign len_sat  = (r_in.expected_length > LEN_CAP) ? LEN_CAP : r_in.expected_length;
    assign seek_hit = (r_phase == PH_SEEK) && (rx == SYNC_BYTE);
    assign ph_b     = seek_hit ? PH_SYNC : r_phase;
    assign sync_b   = seek_hit ? r_count : r_sync;
    assign roff     = $signed({1'b0, r_count}) - $signed({1'b0, sync_b});
    assign pay_lim  = $signed({2'b00, r_len}) - 12'sd5;
    assign pay_b    = (ph_b == PH_SYNC) && (r_cmd == CMD_READ) && (roff >= 11'sd5)
                      && ($signed({roff[10], roff}) < pay_lim);
    assign fits_b   = byte_fits(roff, rx, r_cmd, r_len);
    assign match_b  = r_match && ((ph_b != PH_SYNC) || fits_b);
    assign count_b  = r_count + 10'd1;

    always_comb begin
        lenval_b = r_lenval;
        if (ph_b == PH_SYNC && r_cmd == CMD_LENGTH) begin
            if (roff == 11'sd7) lenval_b = {rx, r_lenval[7:0]};
            if (roff == 11'sd8) lenval_b = {r_lenval[15:8], rx};
        end
    end

    // missing offsets read as zero: closed form over the unreceived tail
    assign lo = $signed({1'b0, r_len}) - $signed({1'b0, sync_b});

    always_comb begin
        vok = (ph_b == PH_SYNC) && match_b;
        if (r_cmd != 8'h00 && lo <= 11'sd2) vok = 1'b0;
        if (r_cmd == CMD_LENGTH && (lo <= 11'sd4 || lenval_b == 16'h0000)) vok = 1'b0;
        if (r_cmd == CMD_READ && sync_b >= 10'd3) vok = 1'b0;
    end

    assign vd_b = (count_b >= r_len) && !pay_b;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sync   = r_sync;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_match  = r_match;
        n_lenval = r_lenval;
        res_load = 1'b0;
        n_res    = '0;
        if (r_in.action == ACT_START) begin
            n_cmd    = r_in.command_code;
            n_len    = len_sat;
            n_count  = 10'd0;
            n_sync   = 10'd0;
            n_match  = 1'b1;
            n_lenval = 16'h0000;
            n_phase  = PH_SEEK;
            if (len_sat == 10'd0) begin
                n_phase          = PH_IDLE;
                res_load         = 1'b1;
                n_res.is_verdict = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            n_phase  = ph_b;
            n_sync   = sync_b;
            n_match  = match_b;
            n_lenval = lenval_b;
            n_count  = count_b;
            if (pay_b) begin
                res_load           = 1'b1;
                n_res.payload_byte = rx;
            end else if (vd_b) begin
                n_phase            = PH_IDLE;
                res_load           = 1'b1;
                n_res.is_verdict   = 1'b1;
                n_res.reply_ok     = vok;
                n_res.frame_length = (vok && r_cmd == CMD_LENGTH) ? lenval_b : 16'h0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_count     <= 10'd0;
            r_sync      <= 10'd0;
            r_cmd       <= 8'h00;
            r_len       <= 10'd0;
            r_match     <= 1'b1;
            r_lenval    <= 16'h0000;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go && res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (go) begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_sync   <= n_sync;
                r_cmd    <= n_cmd;
                r_len    <= n_len;
                r_match  <= n_match;
                r_lenval <= n_lenval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (go && res_load) begin
            r_out <= n_res;
        end
    end

    // image beats only come from a live read reply
    a_pay_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && res_load && !n_res.is_verdict) |-> (r_cmd == CMD_READ && r_phase != PH_IDLE))
        else $error("payload beat outside a read reply");

    a_len_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && res_load && n_res.frame_length != 16'h0000)
            |-> (r_cmd == CMD_LENGTH && n_res.reply_ok))
        else $error("frame length reported for a non-length reply");

    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && res_load && n_res.is_verdict) |=> (r_phase == PH_IDLE))
        else $error("checker still active after verdict");

    a_pay_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_verdict)
            |-> (!o_out_data.reply_ok && o_out_data.frame_length == 16'h0000))
        else $error("payload beat carries verdict fields");

endmodule
